/* rtl/core/mss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_pkg
// Shared types, sizes and codes for the multi-stack shared store.
// ----------------------------------------------------------------------------
package mss_pkg;

  // Sizing
  localparam int NUM_STACKS = 4;
  localparam int CAPACITY   = 16;

  localparam int DATA_W     = 32;
  localparam int SID_W      = 2;
  localparam int ADDR_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LINK_W     = $clog2(CAPACITY + 1);
  localparam int HEAD_IDX_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int SID_EXT_W  = (HEAD_IDX_W > SID_W) ? HEAD_IDX_W : SID_W;

  // Null link is encoded as CAPACITY
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(CAPACITY);

  // Operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  // Input beat
  typedef struct packed {
    logic                     operation;
    logic [SID_W-1:0]         stack_id;
    logic signed [DATA_W-1:0] push_value;
  } mss_in_t;

  // Result beat
  typedef struct packed {
    logic signed [DATA_W-1:0] pop_value;
    logic [1:0]               status;
  } mss_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic issue;   // item taken, memory read launched
    logic commit;  // write-back of links, heads and value
  } mss_cmd_t;

endpackage

/* rtl/core/mss_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_ctrl
// Two-state sequencer: takes a beat, then commits it on the following cycle.
// ----------------------------------------------------------------------------
module mss_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output mss_pkg::mss_cmd_t cmd
);
  import mss_pkg::*;

  localparam logic [0:0] S_IDLE = 1'b0;
  localparam logic [0:0] S_EXEC = 1'b1;

  logic [0:0] state;
  logic [0:0] state_next;

  assign busy       = (state == S_EXEC);
  assign cmd.issue  = start && !busy;
  assign cmd.commit = (state == S_EXEC);

  // Next-state logic
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Checks
  a_issue_then_commit: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |=> cmd.commit)
    else $error("issued beat not committed next cycle");

  a_commit_single: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> !cmd.commit)
    else $error("commit held for more than one cycle");

endmodule

/* rtl/core/mss_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_dp
// Entry store, link store, stack heads and free list with result register.
// ----------------------------------------------------------------------------
module mss_dp (
  input  logic              clk,
  input  logic              rst,
  input  mss_pkg::mss_cmd_t cmd,
  input  mss_pkg::mss_in_t  item,
  output mss_pkg::mss_out_t result,
  output logic              done
);
  import mss_pkg::*;

  // Memories (no reset)
  logic [DATA_W-1:0] val_mem  [CAPACITY];
  logic [LINK_W-1:0] link_mem [CAPACITY];

  // Control state
  logic [LINK_W-1:0] heads [NUM_STACKS];
  logic [LINK_W-1:0] free_head;
  logic [LINK_W-1:0] fill;   // entries below this have had their link written

  // Item held from issue to commit
  logic                  op_q;
  logic [HEAD_IDX_W-1:0] idx_q;
  logic [DATA_W-1:0]     val_q;
  logic [LINK_W-1:0]     slot_q;
  logic [LINK_W-1:0]     head_q;
  logic                  fail_q;
  logic [LINK_W-1:0]     link_rd;
  logic [DATA_W-1:0]     val_rd;

  // Issue-side decode
  logic [SID_EXT_W-1:0]  sid_ext;
  logic [HEAD_IDX_W-1:0] idx;
  logic                  sid_ok;
  logic [LINK_W-1:0]     head_sel;
  logic [LINK_W-1:0]     slot_sel;
  logic                  fail;
  logic [ADDR_W-1:0]     rd_addr;
  logic [ADDR_W-1:0]     wr_addr;
  logic [LINK_W-1:0]     link_eff;

  assign sid_ext  = SID_EXT_W'(item.stack_id);
  assign idx      = sid_ext[HEAD_IDX_W-1:0];
  assign sid_ok   = int'(item.stack_id) < NUM_STACKS;
  assign head_sel = sid_ok ? heads[idx] : NULL_LINK;
  assign slot_sel = (item.operation == OP_PUSH) ? free_head : head_sel;
  assign fail     = (item.operation == OP_PUSH) ? (!sid_ok || free_head == NULL_LINK)
                                                : (head_sel == NULL_LINK);
  assign rd_addr  = slot_sel[ADDR_W-1:0];
  assign wr_addr  = slot_q[ADDR_W-1:0];

  // Entries never pushed are treated as linking to the next entry
  assign link_eff = (slot_q >= fill) ? slot_q + LINK_W'(1) : link_rd;

  // Capture the beat
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      op_q   <= item.operation;
      idx_q  <= idx;
      val_q  <= item.push_value;
      slot_q <= slot_sel;
      head_q <= head_sel;
      fail_q <= fail;
    end
  end

  // Value store
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      val_rd <= val_mem[rd_addr];
    end
    if (cmd.commit && !fail_q && op_q == OP_PUSH) begin
      val_mem[wr_addr] <= val_q;
    end
  end

  // Link store
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      link_rd <= link_mem[rd_addr];
    end
    if (cmd.commit && !fail_q) begin
      link_mem[wr_addr] <= (op_q == OP_PUSH) ? head_q : free_head;
    end
  end

  // Heads, free list and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        heads[i] <= NULL_LINK;
      end
      free_head <= '0;
      fill      <= '0;
    end else if (cmd.commit && !fail_q) begin
      if (op_q == OP_PUSH) begin
        free_head    <= link_eff;
        heads[idx_q] <= slot_q;
        if (slot_q == fill) fill <= fill + LINK_W'(1);
      end else begin
        heads[idx_q] <= link_eff;
        free_head    <= slot_q;
      end
    end
  end

  // Result register and strobe
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result.pop_value <= (!fail_q && op_q == OP_POP) ? val_rd : '0;
      if (!fail_q) begin
        result.status <= ST_OK;
      end else if (op_q == OP_PUSH) begin
        result.status <= ST_OVERFLOW;
      end else begin
        result.status <= ST_UNDERFLOW;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.commit;
    end
  end

  // Checks
  a_done_follows_commit: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> done)
    else $error("result strobe missing after commit");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= NULL_LINK)
    else $error("fill count beyond capacity");

  a_free_head_in_range: assert property (@(posedge clk) disable iff (rst)
    free_head <= fill || free_head == NULL_LINK)
    else $error("free head skips untouched entries");

  a_fail_zero_value: assert property (@(posedge clk) disable iff (rst)
    done && result.status != ST_OK |-> result.pop_value == '0)
    else $error("failed beat carries a value");

endmodule

/* rtl/core/multi_stack_shared_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_stack_shared_store
// Several stacks sharing one entry store, with a linked free list.
// ----------------------------------------------------------------------------
// A beat is taken when start is high and busy is low. A read step reads the
// link and value stores at the selected entry; a commit step writes the link,
// the stack head, the free head and, on a push, the value back. busy is
// high during the commit step after acceptance, so a new beat is only taken once
// the last is committed. The result appears on result with done high for
// exactly one cycle; the receiver cannot stall it, so it must take every
// result as it comes. A failed push reports overflow, a failed pop reports
// underflow, and both return a zero value and change nothing.
// ----------------------------------------------------------------------------
module multi_stack_shared_store (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  mss_pkg::mss_in_t  item,
  output mss_pkg::mss_out_t result,
  output logic              done
);
  import mss_pkg::*;

  mss_cmd_t cmd;

  // Sequencer
  mss_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Stores and list state
  mss_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .item   (item),
    .result (result),
    .done   (done)
  );

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multi-stack shared store. A short directed
// sequence covers empty pops, value extremes, a full store and overflow.
// Random push/pop traffic follows, with the push ratio shifting among
// fill-heavy, balanced and drain-heavy spells. A shadow copy of the values,
// links, heads and free list predicts the result of every random beat and
// untyped directed step. Results are matched in order at the falling edge.
// ----------------------------------------------------------------------------
module tb;
  import mss_pkg::*;

  localparam int N_RANDOM   = 1950;
  localparam int MAX_GAP    = 11;
  localparam int DRAIN_WAIT = 1000;

  typedef logic [LINK_W-1:0] link_t;

  // One directed step; want is only used when typed is set
  typedef struct {
    mss_in_t  beat;
    bit       typed;
    mss_out_t want;
  } dir_row_t;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  mss_in_t  item;
  mss_out_t result;
  logic     done;

  // Shadow state of the store
  logic signed [DATA_W-1:0] shadow_vals  [CAPACITY];
  link_t                    shadow_links [CAPACITY];
  link_t                    shadow_heads [NUM_STACKS];
  link_t                    shadow_free;

  mss_out_t stack_results_due [$];
  dir_row_t directed_rows [$];
  int       errors = 0;

  multi_stack_shared_store uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .result (result),
    .done   (done)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Applies one push or pop to the shadow store and returns its result
  function automatic mss_out_t apply_stack_op(input mss_in_t beat);
    link_t             slot;
    logic [ADDR_W-1:0] addr;
    mss_out_t          res;
    res.pop_value = '0;
    res.status    = ST_OK;
    if (beat.operation == OP_PUSH) begin
      if (int'(beat.stack_id) >= NUM_STACKS || shadow_free >= NULL_LINK) begin
        res.status = ST_OVERFLOW;
      end else begin
        slot                          = shadow_free;
        addr                          = slot[ADDR_W-1:0];
        shadow_free                   = shadow_links[addr];
        shadow_links[addr]            = shadow_heads[beat.stack_id];
        shadow_heads[beat.stack_id]   = slot;
        shadow_vals[addr]             = beat.push_value;
      end
    end else begin
      if (int'(beat.stack_id) >= NUM_STACKS ||
          shadow_heads[beat.stack_id] >= NULL_LINK) begin
        res.status = ST_UNDERFLOW;
      end else begin
        slot                        = shadow_heads[beat.stack_id];
        addr                        = slot[ADDR_W-1:0];
        shadow_heads[beat.stack_id] = shadow_links[addr];
        shadow_links[addr]          = shadow_free;
        shadow_free                 = slot;
        res.pop_value               = shadow_vals[addr];
      end
    end
    return res;
  endfunction

  function automatic dir_row_t make_row(input logic op, input int sid,
                                        input logic [DATA_W-1:0] val,
                                        input bit typed,
                                        input logic [1:0] st,
                                        input logic [DATA_W-1:0] pv);
    dir_row_t r;
    r.beat.operation  = op;
    r.beat.stack_id   = SID_W'(sid);
    r.beat.push_value = val;
    r.typed           = typed;
    r.want.status     = st;
    r.want.pop_value  = pv;
    return r;
  endfunction

  // Drives one beat after an idle gap, waits for it to be taken and
  // returns the predicted result. Returns at the accepting edge.
  task automatic send_beat(input mss_in_t beat, input int gap,
                           output mss_out_t predicted);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= beat;
    // busy only moves on rising edges, so its falling-edge value holds
    // for the next rising edge
    @(negedge clk);
    while (busy !== 1'b0) @(negedge clk);
    @(posedge clk);
    predicted = apply_stack_op(beat);
  endtask

  // Result checker
  always @(negedge clk) begin
    mss_out_t want;
    if (!rst && done) begin
      if (stack_results_due.size() == 0) begin
        $error("unexpected result: pop_value %0d status %0d",
               result.pop_value, result.status);
        errors++;
      end else begin
        want = stack_results_due.pop_front();
        if (result.pop_value !== want.pop_value) begin
          $error("pop_value: expected %0d, got %0d", want.pop_value, result.pop_value);
          errors++;
        end
        if (result.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result.status);
          errors++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    mss_in_t  beat;
    mss_out_t predicted;
    int       push_pct;
    bit       idle_on;
    int       drain_cycles;

    rst   <= 1'b1;
    start <= 1'b0;
    item  <= '0;

    for (int i = 0; i < CAPACITY; i++) begin
      shadow_vals[i]  = '0;
      shadow_links[i] = link_t'(i + 1);
    end
    for (int s = 0; s < NUM_STACKS; s++) shadow_heads[s] = NULL_LINK;
    shadow_free = '0;

    // Directed: empty pops, extremes in and out, fill to overflow
    directed_rows.push_back(make_row(OP_POP,  0, 32'h1234_5678, 1, ST_UNDERFLOW, '0));
    directed_rows.push_back(make_row(OP_POP,  3, 32'hFFFF_FFFF, 1, ST_UNDERFLOW, '0));
    directed_rows.push_back(make_row(OP_PUSH, 0, 32'h7FFF_FFFF, 1, ST_OK, '0));
    directed_rows.push_back(make_row(OP_PUSH, 3, 32'h8000_0000, 1, ST_OK, '0));
    directed_rows.push_back(make_row(OP_POP,  3, 32'h0,         1, ST_OK, 32'h8000_0000));
    directed_rows.push_back(make_row(OP_POP,  0, 32'h0,         1, ST_OK, 32'h7FFF_FFFF));
    directed_rows.push_back(make_row(OP_POP,  0, 32'h0,         1, ST_UNDERFLOW, '0));
    for (int k = 0; k < CAPACITY; k++) begin
      case (k % 4)
        0: directed_rows.push_back(make_row(OP_PUSH, k % 4, 32'hFFFF_FFFF, 1, ST_OK, '0));
        1: directed_rows.push_back(make_row(OP_PUSH, k % 4, 32'h0, 1, ST_OK, '0));
        2: directed_rows.push_back(make_row(OP_PUSH, k % 4, 32'h5555_5555, 1, ST_OK, '0));
        default: directed_rows.push_back(make_row(OP_PUSH, k % 4, 32'hAAAA_AAAA, 1,
                                                  ST_OK, '0));
      endcase
    end
    directed_rows.push_back(make_row(OP_PUSH, 1, 32'h0BAD_F00D, 1, ST_OVERFLOW, '0));
    directed_rows.push_back(make_row(OP_POP,  2, 32'hDEAD_BEEF, 0, ST_OK, '0));
    directed_rows.push_back(make_row(OP_PUSH, 2, 32'hFFFF_FFFF, 0, ST_OK, '0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      send_beat(directed_rows[r].beat, $urandom_range(0, MAX_GAP), predicted);
      stack_results_due.push_back(directed_rows[r].typed ? directed_rows[r].want
                                                         : predicted);
    end

    // Random: push ratio and idling switch every 64 beats
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 64 == 0) begin
        case ($urandom_range(0, 2))
          0: push_pct = 15;
          1: push_pct = 50;
          default: push_pct = 85;
        endcase
        idle_on = ($urandom_range(0, 3) != 0);
      end
      beat.operation = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
      beat.stack_id  = SID_W'($urandom());
      case ($urandom_range(0, 7))
        0: beat.push_value = 32'h7FFF_FFFF;
        1: beat.push_value = 32'h8000_0000;
        2: beat.push_value = '0;
        3: beat.push_value = '1;
        default: beat.push_value = $urandom();
      endcase
      send_beat(beat, idle_on ? $urandom_range(0, MAX_GAP) : 0, predicted);
      stack_results_due.push_back(predicted);
    end
    start <= 1'b0;

    // Drain
    drain_cycles = 0;
    while (stack_results_due.size() != 0 && drain_cycles < DRAIN_WAIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    if (stack_results_due.size() != 0) begin
      $error("%0d results never arrived", stack_results_due.size());
      errors++;
    end
    repeat (4) @(posedge clk);

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
